// File: rtl/core/esc_pkg.sv
// Shared types, constants and arithmetic helpers for the sensor compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_TEMP_TRIM    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_TRIM_A = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_TRIM_B = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_TRIM_C = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM_TRIM     = 3'd4;

  localparam int unsigned FrontDepth = 13;
  localparam int unsigned DivW       = 32;
  localparam int unsigned BackDepth  = 3;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic        [31:0] pressure_pa;
    logic               pressure_valid;
    logic        [6:0]  humidity_percent;
  } out_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [6:0]  hum;
    logic        dbl;
    logic        anz;
  } side_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    side_t       side;
  } div_req_t;

  typedef struct packed {
    logic [31:0] quo;
    side_t       side;
  } div_rsp_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/environment_sensor_compensation_top.sv
// Top level of the sensor compensation block: trim registers and the full pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Compensates one raw temperature, pressure and humidity sample per transaction and
// returns temperature in 0.01 degC, pressure in Pa with a valid flag, and humidity in
// whole percent. A new transaction is taken every cycle unless the output stalls, and
// passes 13 front arithmetic stages, the 32-stage bit-per-cycle pressure divider and 3
// correction stages. Stall on the output freezes the whole pipeline. The user must write
// trim registers via the configuration port only while the block is idle; not enforced.
module environment_sensor_compensation_top
  import esc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  logic [47:0] temp_trim_q;
  logic [63:0] press_trim_a_q, press_trim_b_q, hum_trim_q;
  logic [15:0] press_trim_c_q;
  logic        en;
  logic        fr_valid, dv_valid;
  div_req_t    fr_req;
  div_rsp_t    dv_rsp;

  assign cfg_ready_o = 1'b1;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q    <= '0;
      press_trim_a_q <= '0;
      press_trim_b_q <= '0;
      press_trim_c_q <= '0;
      hum_trim_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEMP_TRIM:    temp_trim_q    <= cfg_data_i[47:0];
        CFG_PRESS_TRIM_A: press_trim_a_q <= cfg_data_i;
        CFG_PRESS_TRIM_B: press_trim_b_q <= cfg_data_i;
        CFG_PRESS_TRIM_C: press_trim_c_q <= cfg_data_i[15:0];
        CFG_HUM_TRIM:     hum_trim_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  esc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .data_i         (in_data_i),
    .temp_trim_i    (temp_trim_q),
    .press_trim_a_i (press_trim_a_q),
    .press_trim_b_i (press_trim_b_q),
    .hum_trim_i     (hum_trim_q),
    .valid_o        (fr_valid),
    .req_o          (fr_req)
  );

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .req_i   (fr_req),
    .valid_o (dv_valid),
    .rsp_o   (dv_rsp)
  );

  esc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (dv_valid),
    .rsp_i          (dv_rsp),
    .press_trim_b_i (press_trim_b_q),
    .press_trim_c_i (press_trim_c_q),
    .valid_o        (out_valid_o),
    .data_o         (out_data_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/esc_front.sv
// Front pipeline: temperature, humidity and pressure terms ahead of the divide.
`timescale 1ns / 1ps
`default_nettype none
module esc_front
  import esc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire in_t         data_i,
  input  wire logic [47:0] temp_trim_i,
  input  wire logic [63:0] press_trim_a_i,
  input  wire logic [63:0] press_trim_b_i,
  input  wire logic [63:0] hum_trim_i,
  output logic             valid_o,
  output div_req_t         req_o
);

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, temp_trim_i[15:0]};
  assign t2 = sx16(temp_trim_i[31:16]);
  assign t3 = sx16(temp_trim_i[47:32]);
  assign p1 = {16'd0, press_trim_a_i[15:0]};
  assign p2 = sx16(press_trim_a_i[31:16]);
  assign p3 = sx16(press_trim_a_i[47:32]);
  assign p4 = sx16(press_trim_a_i[63:48]);
  assign p5 = sx16(press_trim_b_i[15:0]);
  assign p6 = sx16(press_trim_b_i[31:16]);
  assign h1 = {24'd0, hum_trim_i[7:0]};
  assign h2 = sx16(hum_trim_i[23:8]);
  assign h3 = {24'd0, hum_trim_i[31:24]};
  assign h4 = {20'd0, hum_trim_i[43:32]};
  assign h5 = {20'd0, hum_trim_i[55:44]};
  assign h6 = sx8(hum_trim_i[63:56]);

  logic [FrontDepth-1:0] vld_q;

  logic [31:0] s1_m1_q, s1_dd_q;
  logic [19:0] s1_ap_q;
  logic [15:0] s1_ah_q;
  logic [31:0] s2_v1_q, s2_v2m_q;
  logic [19:0] s2_ap_q;
  logic [15:0] s2_ah_q;
  logic [31:0] s3_tf_q;
  logic [19:0] s3_ap_q;
  logic [15:0] s3_ah_q;
  logic [31:0] s4_tm_q, s4_qq_q, s4_ap5_q, s4_p2a_q, s4_h5v_q, s4_vh6_q, s4_vh3_q;
  logic [19:0] s4_ap_q;
  logic [15:0] s4_ah_q;
  logic [31:0] s5_temp_q, s5_b1_q, s5_p3q_q, s5_x_q, s5_ya_q, s5_yb_q, s5_ap5_q, s5_p2a_q;
  logic [19:0] s5_ap_q;
  logic [31:0] s6_b_q, s6_a2_q, s6_ym_q, s6_x_q, s6_temp_q;
  logic [19:0] s6_ap_q;
  logic [31:0] s7_a3m_q, s7_y1_q, s7_b_q, s7_x_q, s7_temp_q;
  logic [19:0] s7_ap_q;
  logic [31:0] s8_a3_q, s8_pn_q, s8_y2m_q, s8_x_q, s8_temp_q;
  logic [31:0] s9_y_q, s9_a3_q, s9_pn_q, s9_x_q, s9_temp_q;
  logic [31:0] s10_xy_q, s10_a3_q, s10_pn_q, s10_temp_q;
  logic [31:0] s11_ss_q, s11_xy_q, s11_a3_q, s11_pn_q, s11_temp_q;
  logic [31:0] s12_hm_q, s12_xy_q, s12_a3_q, s12_pn_q, s12_temp_q;
  div_req_t    req_q;

  logic [31:0] at, d1, a4, q4, vh4, s11, v13, hv13;

  assign at  = {12'd0, data_i.raw_temperature};
  assign d1  = (at >> 4) - t1;
  assign a4  = asr(s3_tf_q, 1) - 32'd64000;
  assign q4  = asr(a4, 2);
  assign vh4 = s3_tf_q - 32'd76800;
  assign s11 = asr(s10_xy_q, 15);
  assign v13 = s12_xy_q - asr(s12_hm_q, 4);

  always_comb begin
    if (v13[31]) begin
      hv13 = 32'd0;
    end else if (v13 > HUM_MAX) begin
      hv13 = HUM_MAX;
    end else begin
      hv13 = v13;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FrontDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_m1_q    <= ((at >> 3) - (t1 << 1)) * t2;
      s1_dd_q    <= d1 * d1;
      s1_ap_q    <= data_i.raw_pressure;
      s1_ah_q    <= data_i.raw_humidity;

      s2_v1_q    <= asr(s1_m1_q, 11);
      s2_v2m_q   <= asr(s1_dd_q, 12) * t3;
      s2_ap_q    <= s1_ap_q;
      s2_ah_q    <= s1_ah_q;

      s3_tf_q    <= s2_v1_q + asr(s2_v2m_q, 14);
      s3_ap_q    <= s2_ap_q;
      s3_ah_q    <= s2_ah_q;

      s4_tm_q    <= s3_tf_q * 32'd5 + 32'd128;
      s4_qq_q    <= q4 * q4;
      s4_ap5_q   <= a4 * p5;
      s4_p2a_q   <= p2 * a4;
      s4_h5v_q   <= h5 * vh4;
      s4_vh6_q   <= vh4 * h6;
      s4_vh3_q   <= vh4 * h3;
      s4_ap_q    <= s3_ap_q;
      s4_ah_q    <= s3_ah_q;

      s5_temp_q  <= asr(s4_tm_q, 8);
      s5_b1_q    <= asr(s4_qq_q, 11) * p6;
      s5_p3q_q   <= p3 * asr(s4_qq_q, 13);
      s5_x_q     <= asr(({16'd0, s4_ah_q} << 14) - (h4 << 20) - s4_h5v_q + 32'd16384, 15);
      s5_ya_q    <= asr(s4_vh6_q, 10);
      s5_yb_q    <= asr(s4_vh3_q, 11) + 32'd32768;
      s5_ap5_q   <= s4_ap5_q;
      s5_p2a_q   <= s4_p2a_q;
      s5_ap_q    <= s4_ap_q;

      s6_b_q     <= asr(s5_b1_q + (s5_ap5_q << 1), 2) + (p4 << 16);
      s6_a2_q    <= asr(asr(s5_p3q_q, 3) + asr(s5_p2a_q, 1), 18);
      s6_ym_q    <= s5_ya_q * s5_yb_q;
      s6_x_q     <= s5_x_q;
      s6_temp_q  <= s5_temp_q;
      s6_ap_q    <= s5_ap_q;

      s7_a3m_q   <= (32'd32768 + s6_a2_q) * p1;
      s7_y1_q    <= asr(s6_ym_q, 10) + 32'd2097152;
      s7_b_q     <= s6_b_q;
      s7_x_q     <= s6_x_q;
      s7_temp_q  <= s6_temp_q;
      s7_ap_q    <= s6_ap_q;

      s8_a3_q    <= asr(s7_a3m_q, 15);
      s8_pn_q    <= ((32'd1048576 - {12'd0, s7_ap_q}) - asr(s7_b_q, 12)) * 32'd3125;
      s8_y2m_q   <= s7_y1_q * h2;
      s8_x_q     <= s7_x_q;
      s8_temp_q  <= s7_temp_q;

      s9_y_q     <= asr(s8_y2m_q + 32'd8192, 14);
      s9_a3_q    <= s8_a3_q;
      s9_pn_q    <= s8_pn_q;
      s9_x_q     <= s8_x_q;
      s9_temp_q  <= s8_temp_q;

      s10_xy_q   <= s9_x_q * s9_y_q;
      s10_a3_q   <= s9_a3_q;
      s10_pn_q   <= s9_pn_q;
      s10_temp_q <= s9_temp_q;

      s11_ss_q   <= s11 * s11;
      s11_xy_q   <= s10_xy_q;
      s11_a3_q   <= s10_a3_q;
      s11_pn_q   <= s10_pn_q;
      s11_temp_q <= s10_temp_q;

      s12_hm_q   <= asr(s11_ss_q, 7) * h1;
      s12_xy_q   <= s11_xy_q;
      s12_a3_q   <= s11_a3_q;
      s12_pn_q   <= s11_pn_q;
      s12_temp_q <= s11_temp_q;

      req_q.num       <= s12_pn_q[31] ? s12_pn_q : {s12_pn_q[30:0], 1'b0};
      req_q.den       <= s12_a3_q;
      req_q.side.temp <= s12_temp_q;
      req_q.side.hum  <= hv13[28:22];
      req_q.side.dbl  <= s12_pn_q[31];
      req_q.side.anz  <= (s12_a3_q != 32'd0);
    end
  end

  assign valid_o = vld_q[FrontDepth-1];
  assign req_o   = req_q;

endmodule
`default_nettype wire

// File: rtl/core/esc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module esc_div
  import esc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  wire div_req_t req_i,
  output logic          valid_o,
  output div_rsp_t      rsp_o
);

  logic [DivW-1:0]   vld_q;
  logic [DivW-1:0]   rem_q  [DivW];
  logic [DivW-1:0]   quo_q  [DivW];
  logic [DivW-1:0]   num_q  [DivW];
  logic [DivW-1:0]   den_q  [DivW];
  side_t             side_q [DivW];

  logic [DivW-1:0]   rem_in  [DivW];
  logic [DivW-1:0]   quo_in  [DivW];
  logic [DivW-1:0]   num_in  [DivW];
  logic [DivW-1:0]   den_in  [DivW];
  side_t             side_in [DivW];
  logic [DivW:0]     trial   [DivW];
  logic [DivW-1:0]   ge;

  always_comb begin
    rem_in[0]  = '0;
    quo_in[0]  = '0;
    num_in[0]  = req_i.num;
    den_in[0]  = req_i.den;
    side_in[0] = req_i.side;
    for (int k = 1; k < DivW; k++) begin
      rem_in[k]  = rem_q[k-1];
      quo_in[k]  = quo_q[k-1];
      num_in[k]  = num_q[k-1];
      den_in[k]  = den_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < DivW; k++) begin
      trial[k] = {rem_in[k], num_in[k][DivW-1]};
      ge[k]    = (trial[k] >= {1'b0, den_in[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivW; k++) begin
        rem_q[k]  <= ge[k] ? DivW'(trial[k] - {1'b0, den_in[k]}) : trial[k][DivW-1:0];
        quo_q[k]  <= {quo_in[k][DivW-2:0], ge[k]};
        num_q[k]  <= {num_in[k][DivW-2:0], 1'b0};
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o    = vld_q[DivW-1];
  assign rsp_o.quo  = quo_q[DivW-1];
  assign rsp_o.side = side_q[DivW-1];

endmodule
`default_nettype wire

// File: rtl/core/esc_back.sv
// Back pipeline: pressure correction after the divide and result register.
`timescale 1ns / 1ps
`default_nettype none
module esc_back
  import esc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire div_rsp_t    rsp_i,
  input  wire logic [63:0] press_trim_b_i,
  input  wire logic [15:0] press_trim_c_i,
  output logic             valid_o,
  output out_t             data_o
);

  logic [31:0] p7, p8, p9, p0;

  assign p7 = sx16(press_trim_b_i[47:32]);
  assign p8 = sx16(press_trim_b_i[63:48]);
  assign p9 = sx16(press_trim_c_i);
  assign p0 = rsp_i.side.dbl ? {rsp_i.quo[30:0], 1'b0} : rsp_i.quo;

  logic [BackDepth-1:0] vld_q;
  logic [31:0] s1_p_q, s1_p8m_q, s1_sq_q;
  side_t       s1_side_q;
  logic [31:0] s2_p_q, s2_p8m_q, s2_v1m_q;
  side_t       s2_side_q;
  out_t        out_q;

  logic [31:0] v1, v2, pf;

  assign v1 = asr(s2_v1m_q, 12);
  assign v2 = asr(s2_p8m_q, 13);
  assign pf = s2_p_q + asr(v1 + v2 + p7, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[BackDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_p_q    <= p0;
      s1_p8m_q  <= (p0 >> 2) * p8;
      s1_sq_q   <= (p0 >> 3) * (p0 >> 3);
      s1_side_q <= rsp_i.side;

      s2_p_q    <= s1_p_q;
      s2_p8m_q  <= s1_p8m_q;
      s2_v1m_q  <= p9 * (s1_sq_q >> 13);
      s2_side_q <= s1_side_q;

      out_q.temperature_centi <= s2_side_q.temp;
      out_q.pressure_pa       <= s2_side_q.anz ? pf : 32'd0;
      out_q.pressure_valid    <= s2_side_q.anz;
      out_q.humidity_percent  <= s2_side_q.hum;
    end
  end

  assign valid_o = vld_q[BackDepth-1];
  assign data_o  = out_q;

endmodule
`default_nettype wire
